// ----- src/ptts_pkg.sv -----
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types, constants and codes of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int unsigned MAX_TASKS_DEF = 8;
    localparam int unsigned MS_W          = 24;
    localparam int unsigned TL_W          = 10;
    localparam int unsigned HANDLE_W      = 16;
    localparam int unsigned PEND_W        = 8;
    localparam int unsigned MAX_RUNS      = 8;
    localparam logic [TL_W-1:0] TICK_LENGTH_RST = 10'd10;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_ADD      = 3'd1,
        OP_DELETE   = 3'd2,
        OP_TICK     = 3'd3,
        OP_DISPATCH = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADIDX = 2'd2,
        ST_IDLE   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_DLY,
        S_DIV_PER,
        S_ADD_WR,
        S_SHIFT,
        S_TICK,
        S_DISP,
        S_OUT
    } t_state;

    // divider control and status
    typedef struct packed {
        logic            start;
        logic [MS_W-1:0] dividend;
        logic [TL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [MS_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- src/ptts_divider.sv -----
// ----------------------------------------------------------------------------
// ptts_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// A zero divisor answers all ones.
// ----------------------------------------------------------------------------
module ptts_divider
    import ptts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(MS_W + 1);

    logic [MS_W-1:0]  r_quo, n_quo;
    logic [TL_W:0]    r_rem, n_rem;
    logic [TL_W-1:0]  r_dsr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [TL_W:0]    w_trial;

    // one shift and compare-subtract step
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[TL_W-1:0], r_quo[MS_W-1]};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(MS_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_dsr == '0) begin
                n_quo  = '1;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (w_trial >= {1'b0, r_dsr}) begin
                    n_rem = w_trial - {1'b0, r_dsr};
                    n_quo = {r_quo[MS_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial;
                    n_quo = {r_quo[MS_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_dsr <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- src/periodic_task_tick_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Time-triggered task table with add, delete, tick and dispatch commands.
// ----------------------------------------------------------------------------
// One command beat is taken while idle. Clear and unused codes go straight
// to the output beat; tick walks the table one entry a cycle; add runs the
// shared 24-step divider twice; delete shifts one entry a cycle; dispatch
// visits one entry a cycle while the output is free, shifting out one-shot
// tasks an entry a cycle, and holds each result beat until taken. Results
// leave through one output register; the table is busy until the last beat (tlast) is taken.
module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
#(
    parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: tick_length
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    // tdata: opcode[2:0], task_handle[18:3], delay_ms[42:19],
    //        period_ms[66:43], task_index[69:67], zero fill [71:70]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    // tdata: status[1:0], slot[4:2], run_handle[20:5], zero fill [23:21]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    localparam int unsigned RW = $clog2(MAX_RUNS + 1);

    t_state r_state, n_state;

    logic [TL_W-1:0]     r_tick_len;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_shift;
    logic [RW-1:0]       r_runs;
    logic                r_disp_shift;
    logic                r_walk_done;
    logic [HANDLE_W-1:0] r_hdl_in;
    logic [MS_W-1:0]     r_per_in;
    logic [MS_W-1:0]     r_dly_tk;

    logic [HANDLE_W-1:0] r_hdl [MAX_TASKS];
    logic [MS_W-1:0]     r_cd  [MAX_TASKS];
    logic [MS_W-1:0]     r_per [MAX_TASKS];
    logic [PEND_W-1:0]   r_pend[MAX_TASKS];

    logic        r_ovalid;
    logic [23:0] r_odata;
    logic        r_olast;
    logic [23:0] r_hold;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    logic [2:0]      w_op;
    logic [IW-1:0]   w_tidx_n;
    logic            w_idx_last;
    logic            w_out_free;
    logic            w_disp_end;
    logic            w_oset;

    assign w_op       = s_axis_tdata[2:0];
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_idx_last = ({1'b0, r_idx} + 1'b1) >= (CW+1)'(r_count);
    assign w_tidx_n   = IW'(s_axis_tdata[69:67]);

    // dispatch walk is over: table end reached or run limit hit
    assign w_disp_end = r_walk_done || ({1'b0, r_idx} >= (CW+1)'(r_count))
                        || (r_runs == RW'(MAX_RUNS));

    // output beat becomes valid: final beat, or a held run pushed out by the next
    assign w_oset = w_out_free && ((r_state == S_OUT)
                    || (r_state == S_DISP && !w_disp_end && r_pend[r_idx] != '0
                        && r_runs != '0));

    ptts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // divider requests
    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = s_axis_tdata[42:19];
        w_dreq.divisor  = r_tick_len;
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready && w_op == OP_ADD
                && r_count < CW'(MAX_TASKS)) begin
            w_dreq.start = 1'b1;
        end else if (r_state == S_DIV_DLY && w_drsp.done) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = r_per_in;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    case (w_op)
                        OP_ADD:
                            n_state = (r_count < CW'(MAX_TASKS)) ? S_DIV_DLY : S_OUT;
                        OP_DELETE:
                            n_state = ({1'b0, s_axis_tdata[69:67]} < (CW+1)'(r_count)
                                       && 32'(s_axis_tdata[69:67]) < MAX_TASKS)
                                      ? S_SHIFT : S_OUT;
                        OP_TICK:     n_state = (r_count != '0) ? S_TICK : S_OUT;
                        OP_DISPATCH: n_state = S_DISP;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_DIV_DLY: if (w_drsp.done) n_state = S_DIV_PER;
            S_DIV_PER: if (w_drsp.done) n_state = S_ADD_WR;
            S_ADD_WR:  n_state = S_OUT;
            S_SHIFT: begin
                if ({1'b0, r_shift} + 2'd2 >= (CW+1)'(r_count)
                        || 32'(r_shift) + 2 > MAX_TASKS) begin
                    n_state = r_disp_shift ? S_DISP : S_OUT;
                end
            end
            S_TICK: if (w_idx_last) n_state = S_OUT;
            S_DISP: begin
                if (w_out_free) begin
                    if (w_disp_end) begin
                        n_state = S_OUT;
                    end else if (r_pend[r_idx] != '0 && r_per[r_idx] == '0
                            && !w_idx_last) begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_OUT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick_len <= TICK_LENGTH_RST;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_disp_shift <= 1'b0;
            r_walk_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tick_len <= i_cfg_wdata;
            if (w_oset) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_hdl_in <= s_axis_tdata[18:3];
                        r_per_in <= s_axis_tdata[66:43];
                        r_idx    <= '0;
                        r_runs   <= '0;
                        r_disp_shift <= 1'b0;
                        r_walk_done  <= 1'b0;
                        r_olast  <= 1'b1;
                        case (w_op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_odata <= {3'b0, 16'b0, 3'b0, ST_OK};
                            end
                            OP_ADD: begin
                                if (r_count >= CW'(MAX_TASKS))
                                    r_odata <= {3'b0, 16'b0, 3'b0, ST_FULL};
                                else
                                    r_odata <= {3'b0, 16'b0, 3'b0, ST_OK};
                            end
                            OP_DELETE: begin
                                r_shift <= w_tidx_n;
                                if (n_state == S_SHIFT) begin
                                    r_odata <= {3'b0, 16'b0, s_axis_tdata[69:67], ST_OK};
                                end else begin
                                    r_odata <= {3'b0, 16'b0, s_axis_tdata[69:67],
                                                ST_BADIDX};
                                end
                            end
                            default: r_odata <= {3'b0, 16'b0, 3'b0, ST_OK};
                        endcase
                    end
                end
                S_DIV_DLY: if (w_drsp.done) r_dly_tk <= w_drsp.quotient;
                S_ADD_WR: begin
                    r_hdl[IW'(r_count)]  <= r_hdl_in;
                    r_cd[IW'(r_count)]   <= r_dly_tk;
                    r_per[IW'(r_count)]  <= w_drsp.quotient;
                    r_pend[IW'(r_count)] <= '0;
                    r_odata[4:2] <= 3'(r_count);
                    r_count <= r_count + 1'b1;
                end
                S_SHIFT: begin
                    if (!({1'b0, r_shift} + 2'd2 > (CW+1)'(r_count)
                            || 32'(r_shift) + 2 > MAX_TASKS)) begin
                        r_hdl[r_shift]  <= r_hdl[r_shift + 1'b1];
                        r_cd[r_shift]   <= r_cd[r_shift + 1'b1];
                        r_per[r_shift]  <= r_per[r_shift + 1'b1];
                        r_pend[r_shift] <= r_pend[r_shift + 1'b1];
                    end
                    r_shift <= r_shift + 1'b1;
                    if (n_state != S_SHIFT) r_count <= r_count - 1'b1;
                end
                S_TICK: begin
                    if (r_cd[r_idx] != '0) begin
                        r_cd[r_idx] <= r_cd[r_idx] - 1'b1;
                    end else begin
                        r_cd[r_idx] <= r_per[r_idx];
                        if (r_pend[r_idx] != '1) r_pend[r_idx] <= r_pend[r_idx] + 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DISP: begin
                    // a found run waits in r_hold until the next one shows it is not last
                    if (w_out_free) begin
                        if (w_disp_end) begin
                            r_olast <= 1'b1;
                            if (r_runs == '0)
                                r_odata <= {3'b0, 16'b0, 3'b0, ST_IDLE};
                            else
                                r_odata <= r_hold;
                        end else if (r_pend[r_idx] != '0) begin
                            r_pend[r_idx] <= r_pend[r_idx] - 1'b1;
                            r_hold <= {3'b0, r_hdl[r_idx], 3'(r_idx), ST_OK};
                            r_runs <= r_runs + 1'b1;
                            if (r_runs != '0) begin
                                r_odata <= r_hold;
                                r_olast <= 1'b0;
                            end
                            if (r_per[r_idx] == '0) begin
                                r_shift      <= r_idx;
                                r_disp_shift <= 1'b1;
                                if (w_idx_last) r_count <= r_count - 1'b1;
                            end else begin
                                r_idx       <= r_idx + 1'b1;
                                r_walk_done <= w_idx_last;
                            end
                        end else begin
                            r_idx       <= r_idx + 1'b1;
                            r_walk_done <= w_idx_last;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_olast <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count beyond table size");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE))
        else $error("command taken while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> (r_state == S_DIV_DLY || r_state == S_DIV_PER))
        else $error("divider result outside an add");

endmodule
